// ===== hdl/table_linear_interpolator_macros.svh =====
// Assertion macros for the table interpolator.
`ifndef TABLE_LINEAR_INTERPOLATOR_MACROS_SVH
`define TABLE_LINEAR_INTERPOLATOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled in reset.
`define TLI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// Next-cycle implication, disabled in reset.
`define TLI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define TLI_ASSERT_IMP(label, ante, cons)
`define TLI_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ===== hdl/tli_pkg.sv =====
package tli_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 24;                 // Q8.24 fraction bits
  localparam int CNT_W       = $clog2(FRAC_W);
  localparam int MAG_W       = DATA_W + 1;         // |dy| fits 33 bits
  localparam int MAG_LO_W    = (MAG_W + 1) / 2;
  localparam int MAG_HI_W    = MAG_W - MAG_LO_W;
  localparam int PROD_W      = FRAC_W + MAG_W;
  localparam int PART_W      = FRAC_W + MAG_LO_W;
  localparam int CFG_W       = 8;
  localparam int PADDR_W     = 3;

  // register map (word index)
  localparam logic REG_ENTRIES = 1'b0;

  // input mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [1:0] {
    KIND_INTERP = 2'd0,
    KIND_BELOW  = 2'd1,
    KIND_ABOVE  = 2'd2
  } kind_e;

  // Index of the last slot in use, with the count clamped to 2..MAX_ENTRIES.
  function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] cnt);
    int n;
    n = int'(cnt);
    if (n < 2) n = 2;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    return IDX_W'(n - 1);
  endfunction

endpackage

// ===== hdl/table_linear_interpolator.sv =====
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  mode_i, entry_index_i, key_i, table_value_i
// out       output     out_valid_o/out_stall_i  interp_value_o, clamp_kind_o
// cfg       input      APB (psel/penable/...)   entries_in_use at byte address 0
//
// A query scans the slots in use, one per cycle through the breakpoint memory read
// port; for interpolation it then runs FETCH, one divider step per fraction bit,
// the MUL_LO and MUL_HI multiply steps and FINISH; a clamped query goes to FINISH
// right after the scan.
// rst_ni clears control state and sets entries_in_use to 2; the table is not cleared.
// A finished result waits in the output register; the input side keeps taking
// transfers while it is stalled, and only a query that finishes then waits for it.
`include "table_linear_interpolator_macros.svh"

module table_linear_interpolator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [6:0]                      entry_index_i,
  input  logic signed [tli_pkg::DATA_W-1:0] key_i,
  input  logic signed [tli_pkg::DATA_W-1:0] table_value_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [tli_pkg::DATA_W-1:0] interp_value_o,
  output logic [1:0]                      clamp_kind_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tli_pkg::PADDR_W-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import tli_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_DIV,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FINISH
  } state_e;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] entries_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ENTRIES);
  assign prdata = (paddr[PADDR_W-1] == REG_ENTRIES) ? {{(32-CFG_W){1'b0}}, entries_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= CFG_W'(2);
    end else if (cfg_wr) begin
      entries_q <= pwdata[CFG_W-1:0];
    end
  end

  // ---------------------------------------------------------------- control regs
  state_e             state_q;
  logic [IDX_W-1:0]   u_q;         // slot whose data sits in the read registers
  logic [CNT_W-1:0]   cnt_q;       // divider step count
  logic [DATA_W-1:0]  key_q;
  logic [DATA_W-1:0]  yh_q;
  logic [DATA_W-1:0]  yl_q;
  logic [DATA_W-1:0]  den_q;
  logic [MAG_W-1:0]   rem_q;
  logic [FRAC_W-1:0]  frac_q;
  logic [MAG_W-1:0]   mag_q;
  logic               neg_q;
  logic [PROD_W-1:0]  prod_q;
  kind_e              kind_q;
  logic               out_valid_q;
  logic [DATA_W-1:0]  out_value_q;
  kind_e              out_kind_q;

  // ---------------------------------------------------------------- table memory
  logic [DATA_W-1:0]  bp_mem  [MAX_ENTRIES];
  logic [DATA_W-1:0]  val_mem [MAX_ENTRIES];
  logic [DATA_W-1:0]  bp_rd_q;
  logic [DATA_W-1:0]  val_rd_q;
  logic [IDX_W-1:0]   rd_addr;
  logic               in_xfer;
  logic               wr_en;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign wr_en      = in_xfer && (mode_i == MODE_WRITE) && (int'(entry_index_i) < MAX_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bp_mem[IDX_W'(entry_index_i)]  <= key_i;
      val_mem[IDX_W'(entry_index_i)] <= table_value_i;
    end
    bp_rd_q  <= bp_mem[rd_addr];
    val_rd_q <= val_mem[rd_addr];
  end

  // ---------------------------------------------------------------- datapath
  logic [IDX_W-1:0]   n_last;
  logic               found;
  logic [MAG_W-1:0]   rem_sh;
  logic               rem_ge;
  logic [MAG_W-1:0]   rem_nx;
  logic [MAG_W-1:0]   dx;
  logic [MAG_W-1:0]   dy;
  logic [MAG_LO_W-1:0] mul_b;
  logic [PART_W-1:0]  mul_p;
  logic [MAG_W-1:0]   q_mag;
  logic [MAG_W-1:0]   q_sgn;
  logic [MAG_W-1:0]   res_full;
  logic               out_free;

  assign n_last = last_index(entries_q);
  // first breakpoint strictly above the key
  assign found  = $signed(bp_rd_q) > $signed(key_q);

  always_comb begin
    rd_addr = u_q;
    unique case (state_q)
      ST_IDLE: rd_addr = '0;
      ST_SCAN: rd_addr = found ? (u_q - 1'b1) : (u_q + 1'b1);
      default: rd_addr = u_q;
    endcase
  end

  // shared restoring divider step: frac = floor(dx * 2^24 / den), dx < den
  assign rem_sh = {rem_q[DATA_W-1:0], 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_q};
  assign rem_nx = rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;

  assign dx = {key_q[DATA_W-1], key_q} - {bp_rd_q[DATA_W-1], bp_rd_q};
  assign dy = {yh_q[DATA_W-1], yh_q} - {val_rd_q[DATA_W-1], val_rd_q};

  // one multiplier, two passes over the halves of |dy|
  assign mul_b = (state_q == ST_MUL_LO) ? mag_q[MAG_LO_W-1:0]
                                        : MAG_LO_W'(mag_q[MAG_W-1:MAG_LO_W]);
  assign mul_p = frac_q * mul_b;

  // truncate toward zero: shift the magnitude, then restore the sign
  assign q_mag    = prod_q[PROD_W-1:FRAC_W];
  assign q_sgn    = neg_q ? (~q_mag + 1'b1) : q_mag;
  assign res_full = {yl_q[DATA_W-1], yl_q} + q_sgn;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      u_q         <= '0;
      cnt_q       <= '0;
      key_q       <= '0;
      yh_q        <= '0;
      yl_q        <= '0;
      den_q       <= '0;
      rem_q       <= '0;
      frac_q      <= '0;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      prod_q      <= '0;
      kind_q      <= KIND_INTERP;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_kind_q  <= KIND_INTERP;
    end else begin
      // in FINISH the output register is reloaded below instead
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer && (mode_i == MODE_QUERY)) begin
            key_q   <= key_i;
            u_q     <= '0;
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (found && (u_q == '0)) begin
            yl_q    <= val_rd_q;
            prod_q  <= '0;
            neg_q   <= 1'b0;
            kind_q  <= KIND_BELOW;
            state_q <= ST_FINISH;
          end else if (found) begin
            den_q   <= bp_rd_q;       // high breakpoint, turned into den in FETCH
            yh_q    <= val_rd_q;
            u_q     <= u_q - 1'b1;
            kind_q  <= KIND_INTERP;
            state_q <= ST_FETCH;
          end else if (u_q == n_last) begin
            yl_q    <= val_rd_q;
            prod_q  <= '0;
            neg_q   <= 1'b0;
            kind_q  <= KIND_ABOVE;
            state_q <= ST_FINISH;
          end else begin
            u_q <= u_q + 1'b1;
          end
        end
        ST_FETCH: begin
          rem_q   <= dx;
          den_q   <= den_q - bp_rd_q;
          yl_q    <= val_rd_q;
          neg_q   <= dy[MAG_W-1];
          mag_q   <= dy[MAG_W-1] ? (~dy + 1'b1) : dy;
          frac_q  <= '0;
          cnt_q   <= CNT_W'(FRAC_W - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q  <= rem_nx;
          frac_q <= {frac_q[FRAC_W-2:0], rem_ge};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == '0) begin
            state_q <= ST_MUL_LO;
          end
        end
        ST_MUL_LO: begin
          prod_q  <= PROD_W'(mul_p);
          state_q <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          prod_q  <= prod_q + {mul_p[PROD_W-MAG_LO_W-1:0], {MAG_LO_W{1'b0}}};
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= res_full[DATA_W-1:0];
            out_kind_q  <= kind_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign interp_value_o = out_value_q;
  assign clamp_kind_o   = out_kind_q;

  // ---------------------------------------------------------------- checks
  `TLI_ASSERT_IMP(a_div_rem_below_den, state_q == ST_DIV, rem_q < {1'b0, den_q})
  `TLI_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, u_q <= n_last)
  `TLI_ASSERT_IMP(a_fetch_after_scan, state_q == ST_FETCH, $past(state_q) == ST_SCAN)
  `TLI_ASSERT_NXT(a_finish_loads_out, (state_q == ST_FINISH) && out_free, out_valid_q)
  `TLI_ASSERT_IMP(a_busy_no_write, state_q != ST_IDLE, !wr_en)

endmodule

// ===== test/tb_table_linear_interpolator.sv =====
`timescale 1ns / 1ps

// Testbench for the piecewise linear table interpolator.
// Write transfers load breakpoint/value slots; query transfers return one result.
// Expected results are computed locally from a mirror of the table and the
// entries_in_use register, queued at input acceptance, and compared in order
// with every output transfer.
module tb_table_linear_interpolator;
  import tli_pkg::*;

  localparam int          DRAIN_CYCLES = 16;
  localparam int unsigned TIMEOUT_NS   = 50_000_000;  // far beyond the slowest legal run
  localparam int          RANDOM_ITEMS = 540;         // table loads and queries together
  localparam int          PHASE_ITEMS  = 40;
  localparam int          SHOWN_ERRORS = 40;

  localparam logic [PADDR_W-1:0] ENTRIES_ADDR = PADDR_W'(4 * REG_ENTRIES);

  localparam logic signed [DATA_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  // Q8.24 constants for the hand-written table
  localparam logic signed [DATA_W-1:0] Q_NEG_TWO  = 32'shfe00_0000;
  localparam logic signed [DATA_W-1:0] Q_NEG_ONE  = 32'shff00_0000;
  localparam logic signed [DATA_W-1:0] Q_HALF     = 32'sh0080_0000;
  localparam logic signed [DATA_W-1:0] Q_TWO      = 32'sh0200_0000;
  localparam logic signed [DATA_W-1:0] Q_THREE    = 32'sh0300_0000;
  localparam logic signed [DATA_W-1:0] Q_3P5      = 32'sh0380_0000;
  localparam logic signed [DATA_W-1:0] Q_NEG_4P25 = 32'shfbc0_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    kind_e                    kind;
  } lookup_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     mode_i;
  logic [6:0]               entry_index_i;
  logic signed [DATA_W-1:0] key_i;
  logic signed [DATA_W-1:0] table_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] interp_value_o;
  logic [1:0]               clamp_kind_o;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  // mirror of the block's table and register
  logic signed [DATA_W-1:0] bp_mirror  [MAX_ENTRIES];
  logic signed [DATA_W-1:0] val_mirror [MAX_ENTRIES];
  logic [CFG_W-1:0]         entries_cfg = CFG_W'(2);

  lookup_t pending_lookups[$];
  int      errors        = 0;
  int      in_gap_max    = 8;
  int      out_stall_max = 8;

  table_linear_interpolator u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= SHOWN_ERRORS) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // register value clamped to 2..MAX_ENTRIES, as the block interprets it
  function automatic int active_slots();
    int n;
    n = int'(entries_cfg);
    if (n < 2) n = 2;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    return n;
  endfunction

  // Expected result of one query against the mirrored table.
  function automatic lookup_t interpolate_lookup(input logic signed [DATA_W-1:0] key);
    int      n;
    int      u;
    longint  xl, xh, yl, yh, frac, prod, res;
    lookup_t r;
    n = active_slots();
    // first slot in use whose breakpoint is strictly above the key
    u = 0;
    while (u < n && bp_mirror[u] <= key) u++;
    if (u == 0) begin
      r.value = val_mirror[0];
      r.kind  = KIND_BELOW;
    end else if (u >= n) begin
      r.value = val_mirror[n-1];
      r.kind  = KIND_ABOVE;
    end else begin
      xl   = bp_mirror[u-1];
      xh   = bp_mirror[u];
      yl   = val_mirror[u-1];
      yh   = val_mirror[u];
      // Q0.24 ratio, then scale dy and drop 24 bits rounding toward zero
      frac = ((longint'(key) - xl) << FRAC_W) / (xh - xl);
      prod = frac * (yh - yl);
      res  = yl + prod / (longint'(1) << FRAC_W);
      r.value = res[DATA_W-1:0];
      r.kind  = KIND_INTERP;
    end
    return r;
  endfunction

  // One input transfer. Valid stays high into the next call when no gap is
  // drawn, so back-to-back transfers never drop valid for a cycle.
  task automatic send_item(input logic mode, input logic [6:0] slot,
                           input logic signed [DATA_W-1:0] key,
                           input logic signed [DATA_W-1:0] value);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    entry_index_i <= slot;
    key_i         <= key;
    table_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    if (mode == MODE_WRITE) begin
      bp_mirror[slot]  = key;
      val_mirror[slot] = value;
    end else begin
      pending_lookups.push_back(interpolate_lookup(key));
    end
  endtask

  task automatic write_slot(input logic [6:0] slot, input logic signed [DATA_W-1:0] bp,
                            input logic signed [DATA_W-1:0] value);
    send_item(MODE_WRITE, slot, bp, value);
  endtask

  // unused payload fields of a query get random bits
  task automatic query_key(input logic signed [DATA_W-1:0] key);
    send_item(MODE_QUERY, 7'($urandom), key, 32'($urandom));
  endtask

  // Drop valid, drain all results, then give a trailing write time to retire.
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write of entries_in_use followed by a read-back, only with the block idle.
  task automatic load_entry_count(input logic [CFG_W-1:0] count);
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ENTRIES_ADDR;
    pwdata  <= 32'(count);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    entries_cfg = count;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CFG_W-1:0] !== count)
      report_mismatch($sformatf("entries_in_use read %0d, wrote %0d", prdata[CFG_W-1:0], count));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Query key aimed at the interesting spots of the table in use.
  function automatic logic signed [DATA_W-1:0] pick_key(input int n);
    int     r;
    longint span;
    logic signed [DATA_W-1:0] k;
    r = $urandom_range(0, n - 1);
    case ($urandom_range(0, 7))
      0, 1: k = bp_mirror[r];
      2:    k = bp_mirror[r] - 1;
      3:    k = bp_mirror[r] + 1;
      4, 5: begin
        span = (r < n - 1) ? longint'(bp_mirror[r+1]) - longint'(bp_mirror[r]) : 0;
        if (span > 0) k = 32'(longint'(bp_mirror[r]) + longint'($urandom) % span);
        else k = 32'($urandom);
      end
      6:       k = 32'($urandom);
      default: k = $urandom_range(0, 1) ? KEY_MAX : KEY_MIN;
    endcase
    return k;
  endfunction

  // Load slots 0..n-1 with nondecreasing breakpoints; either spread over the
  // whole Q8.24 range or packed tightly, with an occasional repeated breakpoint.
  task automatic fill_sorted(input int n);
    longint pos, step_max;
    if ($urandom_range(0, 1)) begin
      pos      = longint'(KEY_MIN) + $urandom_range(0, 255);
      step_max = (longint'(1) << 32) / n - 8;
    end else begin
      pos      = longint'($signed($urandom)) / 4;
      step_max = $urandom_range(1, 1 << 16);
    end
    for (int i = 0; i < n; i++) begin
      write_slot(7'(i), 32'(pos),
                 ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? KEY_MAX : KEY_MIN)
                                             : 32'($urandom));
      if ($urandom_range(0, 15) != 0) pos += 1 + longint'($urandom) % step_max;
    end
  endtask

  function automatic int pick_idle();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      default: return 8;
    endcase
  endfunction

  // Two-entry table right after reset: below, on and between the
  // breakpoints, just under the last, on the last and above it.
  task automatic test_default_count();
    write_slot(7'd0, Q_NEG_ONE, Q_3P5);
    write_slot(7'd1, Q_TWO, Q_NEG_4P25);
    query_key(Q_NEG_TWO);
    query_key(Q_NEG_ONE);
    query_key(Q_HALF);
    query_key(Q_TWO - 1);
    query_key(Q_TWO);
    query_key(Q_THREE);
  endtask

  // Full-range breakpoints and values: largest dx, den and |dy| of both signs,
  // zero slope, and a repeated breakpoint.
  task automatic test_field_extremes();
    load_entry_count(CFG_W'(2));
    write_slot(7'd0, KEY_MIN, KEY_MIN);
    write_slot(7'd1, KEY_MAX, KEY_MAX);
    query_key(KEY_MIN);
    query_key(KEY_MIN + 1);
    query_key('0);
    query_key(KEY_MAX - 1);
    query_key(KEY_MAX);
    write_slot(7'd0, KEY_MIN, KEY_MAX);
    write_slot(7'd1, KEY_MAX, KEY_MIN);
    query_key(KEY_MIN + 1);
    query_key(-1);
    query_key(KEY_MAX - 1);
    write_slot(7'd1, KEY_MAX, KEY_MAX);
    query_key(Q_HALF);
    write_slot(7'd1, KEY_MIN, Q_TWO);
    query_key(KEY_MIN);
    query_key('0);
  endtask

  // Register values below 2 and above the table depth clamp; the whole table
  // is written first so any clamped count reads only written slots.
  task automatic test_count_register();
    logic [CFG_W-1:0] counts[7];
    counts = '{CFG_W'(0), CFG_W'(1), CFG_W'(255), CFG_W'(129), CFG_W'(128),
               CFG_W'(3), CFG_W'(64)};
    fill_sorted(MAX_ENTRIES);
    foreach (counts[i]) begin
      load_entry_count(counts[i]);
      repeat (8) query_key(pick_key(active_slots()));
    end
  endtask

  // Breakpoints in random order: the scan still takes the first slot above the key.
  task automatic test_unsorted_table();
    int n;
    n = $urandom_range(4, 12);
    for (int i = 0; i < n; i++) write_slot(7'(i), 32'($urandom), 32'($urandom));
    load_entry_count(CFG_W'(n));
    repeat (PHASE_ITEMS) query_key(pick_key(n));
  endtask

  // Phases of fresh sorted tables, mostly small, with random idling per phase.
  // Queries dominate; the stray writes retune values, scribble over slots or
  // land outside the slots in use.
  task automatic test_random_lookups();
    int sent;
    int v;
    int n;
    logic [6:0] slot;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: v = $urandom_range(2, 8);
        6, 7:             v = $urandom_range(9, 32);
        8:                v = MAX_ENTRIES;
        default:          v = $urandom_range(MAX_ENTRIES + 1, 255);
      endcase
      n = (v > MAX_ENTRIES) ? MAX_ENTRIES : v;
      in_gap_max    = pick_idle();
      out_stall_max = pick_idle();
      fill_sorted(n);
      load_entry_count(CFG_W'(v));
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0) begin
          slot = 7'($urandom);
          write_slot(slot, (slot < n && $urandom_range(0, 1)) ? bp_mirror[slot] : 32'($urandom),
                     32'($urandom));
        end else begin
          query_key(pick_key(n));
        end
      end
      sent += n + PHASE_ITEMS;
    end
  endtask

  // Result side: stall for a drawn number of cycles in which a result is
  // offered, then take one transfer and check it against the oldest expectation.
  initial begin : result_side
    int      hold;
    lookup_t want;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = $urandom_range(0, out_stall_max);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        while (hold > 0) begin
          @(posedge clk_i);
          if (out_valid_o) hold--;
        end
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d kind %0d",
                                  interp_value_o, clamp_kind_o));
      end else begin
        want = pending_lookups.pop_front();
        if (interp_value_o !== want.value)
          report_mismatch($sformatf("interp_value got %0d want %0d", interp_value_o, want.value));
        if (clamp_kind_o !== want.kind)
          report_mismatch($sformatf("clamp_kind got %0d want %0d", clamp_kind_o, want.kind));
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    mode_i        <= MODE_WRITE;
    entry_index_i <= '0;
    key_i         <= '0;
    table_value_i <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_count();
    test_field_extremes();
    test_count_register();
    test_unsorted_table();
    test_random_lookups();

    settle_block();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
